### hw/rtl/wbsm_pkg.sv
// write buffer slot manager package: field widths, command and error codes,
// controller to datapath command struct. no dependencies
`default_nettype none

package wbsm_pkg;

  localparam int unsigned SlotsDefault     = 64;
  localparam int unsigned DataWidthDefault = 64;

  localparam int unsigned SlotW    = 6;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned CountW   = 7;
  localparam int unsigned ErrW     = 2;

  typedef enum logic {
    CMD_STORE   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK             = 2'd0,
    ERR_EMPTY_RELEASE  = 2'd1,
    ERR_OCCUPIED_STORE = 2'd2
  } err_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/wbsm_if.sv
// item channels of the write buffer slot manager: request in, result out
// depends on wbsm_pkg
`default_nettype none

interface wbsm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [wbsm_pkg::SlotW-1:0]    slot;
  logic [wbsm_pkg::PayloadW-1:0] payload;

  modport source (output valid, output cmd, output slot, output payload, input ready);
  modport sink   (input valid, input cmd, input slot, input payload, output ready);
endinterface

interface wbsm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         grant_valid;
  logic [wbsm_pkg::SlotW-1:0]    grant_slot;
  logic                         media_valid;
  logic [wbsm_pkg::PayloadW-1:0] media_data;
  logic [wbsm_pkg::ErrW-1:0]     error_code;
  logic                         stalled;
  logic [wbsm_pkg::CountW-1:0]   occupied_count;
  logic                         full_res;

  modport source (
    output valid, output grant_valid, output grant_slot, output media_valid,
    output media_data, output error_code, output stalled, output occupied_count,
    output full_res, input ready
  );
  modport sink (
    input valid, input grant_valid, input grant_slot, input media_valid,
    input media_data, input error_code, input stalled, input occupied_count,
    input full_res, output ready
  );
endinterface

`default_nettype wire

### hw/rtl/wbsm_ctrl.sv
// controller of the write buffer slot manager: idle/execute sequencing and
// result valid flag. depends on wbsm_pkg
`default_nettype none

module wbsm_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output wbsm_pkg::ctrl_cmd_t  cmd_o
);
  import wbsm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = in_valid_i && (state_q == ST_IDLE);
    cmd_o.execute = (state_q == ST_EXEC) && out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_o.execute) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wbsm_dp.sv
// datapath of the write buffer slot manager: slot data memory, occupancy map,
// lowest free slot encoder, occupancy counter and result register. depends on wbsm_pkg
`default_nettype none

module wbsm_dp #(
  parameter int unsigned SLOTS      = wbsm_pkg::SlotsDefault,
  parameter int unsigned DATA_WIDTH = wbsm_pkg::DataWidthDefault
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wbsm_pkg::ctrl_cmd_t            cmd_i,
  input  wire                            cmd_in_i,
  input  wire [wbsm_pkg::SlotW-1:0]      slot_i,
  input  wire [wbsm_pkg::PayloadW-1:0]   payload_i,
  output logic                           grant_valid_o,
  output logic [wbsm_pkg::SlotW-1:0]     grant_slot_o,
  output logic                           media_valid_o,
  output logic [wbsm_pkg::PayloadW-1:0]  media_data_o,
  output logic [wbsm_pkg::ErrW-1:0]      error_code_o,
  output logic                           stalled_o,
  output logic [wbsm_pkg::CountW-1:0]    occupied_count_o,
  output logic                           full_res_o
);
  import wbsm_pkg::*;

  // only the slots an item can name get storage
  localparam int unsigned MaxAddr = 1 << SlotW;
  localparam int unsigned NumAddr = (SLOTS < MaxAddr) ? SLOTS : MaxAddr;
  localparam int unsigned AddrW   = $clog2(NumAddr);
  localparam int unsigned IdxW    = $clog2(NumAddr + 1);
  localparam int unsigned CntW    = $clog2(SLOTS + 1);
  localparam logic        Beyond  = (SLOTS > NumAddr);
  localparam logic [SlotW:0] NumAddrW = (SlotW+1)'(NumAddr);

  logic [DATA_WIDTH-1:0] mem [NumAddr];
  logic [DATA_WIDTH-1:0] rd_data_q;

  logic                  cmd_q;
  logic [SlotW-1:0]      slot_q;
  logic [DATA_WIDTH-1:0] pay_q;

  logic [NumAddr-1:0] occ_q, occ_d;
  logic               stall_q, stall_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  logic [AddrW-1:0] idx;
  logic             in_range, hit, do_write, search, free_any, mvalid;
  logic [IdxW-1:0]  lowest;
  err_e             err;

  logic [IdxW+SlotW-1:0]   gslot_ext;
  logic [CntW+CountW-1:0]  cnt_ext;

  // item capture and registered memory read
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q     <= cmd_in_i;
      slot_q    <= slot_i;
      pay_q     <= payload_i[DATA_WIDTH-1:0];
      rd_data_q <= mem[slot_i[AddrW-1:0]];
    end
    if (cmd_i.execute && do_write) begin
      mem[idx] <= pay_q;
    end
  end

  assign idx      = slot_q[AddrW-1:0];
  assign in_range = {1'b0, slot_q} < NumAddrW;
  assign hit      = in_range && occ_q[idx];

  always_comb begin
    occ_d    = occ_q;
    cnt_d    = cnt_q;
    err      = ERR_OK;
    mvalid   = 1'b0;
    do_write = 1'b0;
    search   = 1'b0;
    if (cmd_q == CMD_STORE) begin
      search = 1'b1;
      if (in_range && !hit) begin
        occ_d[idx] = 1'b1;
        cnt_d      = cnt_q + CntW'(1);
        do_write   = 1'b1;
      end else begin
        err = ERR_OCCUPIED_STORE;
      end
    end else begin
      if (hit) begin
        occ_d[idx] = 1'b0;
        cnt_d      = cnt_q - CntW'(1);
        mvalid     = 1'b1;
        search     = stall_q;
      end else begin
        err = ERR_EMPTY_RELEASE;
      end
    end
  end

  // lowest free slot over the updated occupancy map
  always_comb begin
    lowest = IdxW'(NumAddr);
    for (int i = NumAddr - 1; i >= 0; i--) begin
      if (!occ_d[i]) lowest = IdxW'(i);
    end
  end

  assign free_any = !(&occ_d) || Beyond;
  assign stall_d  = search ? !free_any : stall_q;

  assign gslot_ext = {{SlotW{1'b0}}, lowest};
  assign cnt_ext   = {{CountW{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      stall_q <= 1'b0;
      cnt_q   <= '0;
    end else if (cmd_i.execute) begin
      occ_q   <= occ_d;
      stall_q <= stall_d;
      cnt_q   <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      grant_valid_o    <= search && free_any;
      grant_slot_o     <= (search && free_any) ? gslot_ext[SlotW-1:0] : '0;
      media_valid_o    <= mvalid;
      media_data_o     <= mvalid ? PayloadW'(rd_data_q) : '0;
      error_code_o     <= err;
      stalled_o        <= stall_d;
      occupied_count_o <= cnt_ext[CountW-1:0];
      full_res_o       <= (cnt_d == CntW'(SLOTS));
    end
  end

endmodule

`default_nettype wire

### hw/rtl/write_buffer_slot_manager.sv
// write buffer slot manager top level: joins controller and datapath to the
// item channels. depends on wbsm_pkg, wbsm_if, wbsm_ctrl, wbsm_dp
//
// in_i carries store and release requests (cmd, slot, payload); out_o gives one
// result item per request: grant, media transfer, error code, stall flag,
// occupancy and full flag.
// an item is taken in the idle state; the execute step then uses the slot word
// (registered memory read done at capture), updates the occupancy map, runs
// the lowest free slot encoder over it and loads the result register.
// a new item is taken only once the current one has executed, as set by the
// capture/execute sequence around the single-port slot data memory.
// a stalled receiver holds the result register; the execute step waits while
// it is full and not taken, so at most one result is held back.
// reset clears occupancy, stall flag and count at once; slot data is not
// cleared, there is no clearing pass and the block takes items right away.
`default_nettype none

module write_buffer_slot_manager #(
  parameter int unsigned SLOTS      = wbsm_pkg::SlotsDefault,
  parameter int unsigned DATA_WIDTH = wbsm_pkg::DataWidthDefault
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  wbsm_in_if.sink       in_i,
  wbsm_out_if.source    out_o
);
  import wbsm_pkg::*;

  ctrl_cmd_t cmd;

  wbsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  wbsm_dp #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cmd_in_i         (in_i.cmd),
    .slot_i           (in_i.slot),
    .payload_i        (in_i.payload),
    .grant_valid_o    (out_o.grant_valid),
    .grant_slot_o     (out_o.grant_slot),
    .media_valid_o    (out_o.media_valid),
    .media_data_o     (out_o.media_data),
    .error_code_o     (out_o.error_code),
    .stalled_o        (out_o.stalled),
    .occupied_count_o (out_o.occupied_count),
    .full_res_o       (out_o.full_res)
  );

endmodule

`default_nettype wire
